// File: rtl/core/dcf77_time_code_modulator_macros.svh
// assertion macros for the dcf77 time code modulator
`ifndef DCF77_TIME_CODE_MODULATOR_MACROS_SVH
`define DCF77_TIME_CODE_MODULATOR_MACROS_SVH

`ifndef SYNTHESIS

// checked property, disabled while the active-low reset is asserted
`define DCF_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("dcf77 assertion failed");

// implication whose consequent is checked in the next cycle
`define DCF_ASSERT_NEXT(lbl, clk, rstn, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error("dcf77 assertion failed");

`else

`define DCF_ASSERT(lbl, clk, rstn, prop)
`define DCF_ASSERT_NEXT(lbl, clk, rstn, cond, prop)

`endif

`endif

// File: rtl/core/dcf77_pkg.sv
// package with types, constants and frame encoding for the dcf77 time code modulator
package dcf77_pkg;

    localparam int MINUTES_PER_HOUR = 60;
    localparam int HOURS_PER_DAY    = 24;
    localparam int MARKER_SECOND    = 59;
    localparam int LAST_TENTH       = 9;
    localparam int SUNDAY_CODE      = 7;
    localparam int BCD_RECIP        = 205;  // x / 10 == (x * 205) >> 11 for x < 1024
    localparam int BCD_SHIFT        = 11;

    localparam logic [5:0] SECOND_NONE = 6'd63;

    // frame positions
    localparam int POS_DST_ON   = 17;
    localparam int POS_DST_OFF  = 18;
    localparam int POS_START    = 20;
    localparam int POS_MIN_LO   = 21;
    localparam int POS_MIN_PAR  = 28;
    localparam int POS_HOUR_LO  = 29;
    localparam int POS_HOUR_PAR = 35;
    localparam int POS_DAY_LO   = 36;
    localparam int POS_WDAY_LO  = 42;
    localparam int POS_MON_LO   = 45;
    localparam int POS_YEAR_LO  = 50;
    localparam int POS_DATE_PAR = 58;

    localparam int FRAME_W  = 64;
    localparam int TDATA_IW = 40;
    localparam int TDATA_OW = 8;

    typedef logic [1:0] t_symbol;
    localparam t_symbol SYM_MARKER = 2'd0;
    localparam t_symbol SYM_ZERO   = 2'd1;
    localparam t_symbol SYM_ONE    = 2'd2;

    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day;
        logic [2:0] weekday;
        logic [3:0] month;
        logic [6:0] year_of_century;
        logic       summer_time;
    } t_time;

    // binary to packed bcd by reciprocal multiply, tens in the high nibble
    function automatic logic [7:0] dcf_to_bcd(input logic [7:0] v);
        logic [15:0] prod;
        logic [4:0]  tens;
        logic [7:0]  units;
        prod  = 16'(v) * 16'(BCD_RECIP);
        tens  = prod[15:BCD_SHIFT];
        units = v - 8'(tens) * 8'd10;
        return {tens[3:0], units[3:0]};
    endfunction

    // whole minute frame for the minute after the given time
    function automatic logic [FRAME_W-1:0] dcf_frame(input t_time t);
        logic [6:0] mins;
        logic [5:0] hrs;
        logic [2:0] wd;
        logic [7:0] b_min;
        logic [7:0] b_hour;
        logic [7:0] b_day;
        logic [7:0] b_mon;
        logic [7:0] b_year;
        logic [FRAME_W-1:0] w;
        mins = 7'(t.minute) + 7'd1;
        hrs  = 6'(t.hour);
        if (mins >= 7'(MINUTES_PER_HOUR)) begin
            mins = '0;
            hrs  = hrs + 6'd1;
            if (hrs >= 6'(HOURS_PER_DAY)) begin
                hrs = hrs - 6'(HOURS_PER_DAY);
            end
        end
        // sunday goes out as seven
        wd     = (t.weekday == 3'd0) ? 3'(SUNDAY_CODE) : t.weekday;
        b_min  = dcf_to_bcd(8'(mins));
        b_hour = dcf_to_bcd(8'(hrs));
        b_day  = dcf_to_bcd(8'(t.day));
        b_mon  = dcf_to_bcd(8'(t.month));
        b_year = dcf_to_bcd(8'(t.year_of_century));
        w = '0;
        w[POS_DST_ON]                   = t.summer_time;
        w[POS_DST_OFF]                  = !t.summer_time;
        w[POS_START]                    = 1'b1;
        w[POS_MIN_LO +: 7]              = b_min[6:0];
        w[POS_MIN_PAR]                  = ^b_min[6:0];
        w[POS_HOUR_LO +: 6]             = b_hour[5:0];
        w[POS_HOUR_PAR]                 = ^b_hour[5:0];
        w[POS_DAY_LO +: 6]              = b_day[5:0];
        w[POS_WDAY_LO +: 3]             = wd;
        w[POS_MON_LO +: 5]              = b_mon[4:0];
        w[POS_YEAR_LO +: 8]             = b_year;
        w[POS_DATE_PAR]                 = ^w[POS_DATE_PAR-1:POS_DAY_LO];
        return w;
    endfunction

endpackage

// File: rtl/core/dcf77_time_code_modulator.sv
// dcf77 time code modulator top level: one 100 ms tick in, one carrier item out
// input accept to output valid passes the input register, then the result register
// throughput: 1 item per cycle while the output is not stalled; the frame encode and the
//   phase/carrier update lie between the registers, state updates once per active item
// reset: synchronous active-low; clears handshake valids, enable, prev second (to 63),
//   tenth counter and carrier state
`include "dcf77_time_code_modulator_macros.svh"

module dcf77_time_code_modulator
    import dcf77_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // config register: transmit enable
    input  logic                i_cfg_wr_en,
    input  logic                i_cfg_wr_data,
    // tick input
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // second[5:0], minute[11:6], hour[16:12], day[21:17], weekday[24:22],
    // month[28:25], year_of_century[35:29], summer_time[36], zero pad[39:37]
    input  logic [TDATA_IW-1:0] s_axis_tdata,
    // time_valid[0]
    input  logic                s_axis_tuser,
    // carrier output
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // carrier_on[0], symbol[2:1], tenth[6:3], zero pad[7]
    output logic [TDATA_OW-1:0] m_axis_tdata
);

    // config
    logic r_enable;

    // input register
    logic  r_in_valid;
    logic  r_in_tv;
    t_time r_in_time;

    // result register
    logic       r_out_valid;
    logic       r_out_carrier;
    t_symbol    r_out_symbol;
    logic [3:0] r_out_tenth;

    // modulator state
    logic [5:0] r_prev_second;
    logic [3:0] r_tenth_count;
    logic       r_carrier;

    logic                w_out_ready;
    logic                w_adv;
    logic                w_active;
    logic [5:0]          w_sec;
    logic [3:0]          w_phase;
    logic [FRAME_W-1:0]  w_frame;
    t_symbol             w_sym;
    logic                n_carrier;
    logic [3:0]          n_tenth;
    t_time               w_in_time;

    // handshake: the input register refills in the same cycle it drains
    assign w_out_ready   = !r_out_valid || m_axis_tready;
    assign w_adv         = r_in_valid && w_out_ready;
    assign s_axis_tready = !r_in_valid || w_out_ready;

    // unpack the incoming item
    always_comb begin
        w_in_time.second          = s_axis_tdata[5:0];
        w_in_time.minute          = s_axis_tdata[11:6];
        w_in_time.hour            = s_axis_tdata[16:12];
        w_in_time.day             = s_axis_tdata[21:17];
        w_in_time.weekday         = s_axis_tdata[24:22];
        w_in_time.month           = s_axis_tdata[28:25];
        w_in_time.year_of_century = s_axis_tdata[35:29];
        w_in_time.summer_time     = s_axis_tdata[36];
    end

    // ticks without valid time or with the transmitter off leave the modulator state alone
    assign w_active = r_enable && r_in_tv;
    assign w_sec    = r_in_time.second;

    // a new second restarts the tenth phase
    assign w_phase = (w_sec != r_prev_second) ? 4'd0 : r_tenth_count;

    assign w_frame = dcf_frame(r_in_time);

    // seconds 59..63 are all the minute marker
    always_comb begin
        if (w_sec >= 6'(MARKER_SECOND)) begin
            w_sym = SYM_MARKER;
        end else if (w_frame[w_sec]) begin
            w_sym = SYM_ONE;
        end else begin
            w_sym = SYM_ZERO;
        end
    end

    // pulse shape: reduce at phase 0 (except marker), back up at 1 for a zero bit,
    // back up at 2 always
    always_comb begin
        n_carrier = r_carrier;
        priority if (w_phase == 4'd0) begin
            n_carrier = (w_sym == SYM_MARKER);
        end else if (w_phase == 4'd1) begin
            if (w_sym == SYM_ZERO) begin
                n_carrier = 1'b1;
            end
        end else if (w_phase == 4'd2) begin
            n_carrier = 1'b1;
        end else begin
            n_carrier = r_carrier;
        end
    end

    assign n_tenth = (w_phase >= 4'(LAST_TENTH)) ? 4'd0 : w_phase + 4'd1;

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable      <= 1'b0;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_prev_second <= SECOND_NONE;
            r_tenth_count <= 4'd0;
            r_carrier     <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_enable <= i_cfg_wr_data;
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_out_ready) begin
                r_out_valid <= r_in_valid;
            end
            if (w_adv && w_active) begin
                r_prev_second <= w_sec;
                r_tenth_count <= n_tenth;
                r_carrier     <= n_carrier;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_tv   <= s_axis_tuser;
            r_in_time <= w_in_time;
        end
        if (w_adv) begin
            if (w_active) begin
                r_out_carrier <= n_carrier;
                r_out_symbol  <= w_sym;
                r_out_tenth   <= w_phase;
            end else begin
                // ignored tick reports the held state
                r_out_carrier <= r_carrier;
                r_out_symbol  <= SYM_MARKER;
                r_out_tenth   <= r_tenth_count;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_tenth, r_out_symbol, r_out_carrier};

    // tenth counter never leaves its range
    `DCF_ASSERT(a_tenth_range, i_clk, i_rst_n, r_tenth_count <= 4'(LAST_TENTH))
    // a held item that cannot drain blocks the input
    `DCF_ASSERT(a_in_blocks, i_clk, i_rst_n, (r_in_valid && !w_out_ready) |-> !s_axis_tready)
    // an item leaving the input register shows up as a valid result
    `DCF_ASSERT_NEXT(a_adv_out, i_clk, i_rst_n, w_adv, r_out_valid)

endmodule

// File: bench/tb.sv
// self-checking testbench for the dcf77 time code modulator: ticks, stalls, config phases
module tb;
    import dcf77_pkg::*;

    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off that backs up the block
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake before giving up
    localparam int DRAIN_CYCLES   = 8;     // settle time after the last result
    localparam int MAX_REPORTS    = 10;

    // one expected carrier item
    typedef struct packed {
        logic       carrier_on;
        t_symbol    sym;
        logic [3:0] tenth;
    } t_carrier;

    // tracks the modulator state and holds the carrier items still to come
    class t_carrier_scoreboard;
        bit         tx_enable;
        logic [5:0] last_second;
        logic [3:0] tenth_count;
        logic       carrier_state;
        t_carrier   expected_q[$];
        int         errors;

        function new();
            tx_enable     = 1'b0;
            last_second   = SECOND_NONE;
            tenth_count   = '0;
            carrier_state = 1'b0;
            errors        = 0;
        endfunction

        function void set_enable(bit v);
            tx_enable = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [7:0] to_bcd(int unsigned v);
            int unsigned r;
            r = ((v / 10) << 4) | (v % 10);
            return r[7:0];
        endfunction

        // symbol sent in the given second for the minute after t
        function t_symbol frame_symbol(t_time t);
            int unsigned s;
            int unsigned mins;
            int unsigned hrs;
            int unsigned wd;
            logic [7:0]  b;
            logic [63:0] w;
            s = t.second;
            if (s >= MARKER_SECOND) return SYM_MARKER;
            if (s == POS_DST_ON) return t.summer_time ? SYM_ONE : SYM_ZERO;
            if (s == POS_DST_OFF) return t.summer_time ? SYM_ZERO : SYM_ONE;
            if (s < POS_START) return SYM_ZERO;
            if (s == POS_START) return SYM_ONE;
            mins = t.minute + 1;
            hrs  = t.hour;
            if (mins >= MINUTES_PER_HOUR) begin
                mins = 0;
                hrs  = (hrs + 1) % HOURS_PER_DAY;
            end
            wd = (t.weekday == 0) ? SUNDAY_CODE : t.weekday;
            w  = '0;
            b  = to_bcd(mins);
            w[POS_MIN_LO +: 7] = b[6:0];
            w[POS_MIN_PAR]     = ^w[POS_MIN_PAR-1:POS_MIN_LO];
            b  = to_bcd(hrs);
            w[POS_HOUR_LO +: 6] = b[5:0];
            w[POS_HOUR_PAR]     = ^w[POS_HOUR_PAR-1:POS_HOUR_LO];
            b  = to_bcd(t.day);
            w[POS_DAY_LO +: 6]  = b[5:0];
            b  = to_bcd(wd);
            w[POS_WDAY_LO +: 3] = b[2:0];
            b  = to_bcd(t.month);
            w[POS_MON_LO +: 5]  = b[4:0];
            b  = to_bcd(t.year_of_century);
            w[POS_YEAR_LO +: 8] = b;
            w[POS_DATE_PAR]     = ^w[POS_DATE_PAR-1:POS_DAY_LO];
            return w[s] ? SYM_ONE : SYM_ZERO;
        endfunction

        function void note_tick(logic valid, t_time t);
            t_carrier   res;
            logic [3:0] phase;
            if (!tx_enable || !valid) begin
                // ignored tick reports the held state
                res.carrier_on = carrier_state;
                res.sym        = SYM_MARKER;
                res.tenth      = tenth_count;
            end else begin
                if (t.second != last_second) begin
                    last_second = t.second;
                    tenth_count = '0;
                end
                res.sym = frame_symbol(t);
                phase   = tenth_count;
                case (phase)
                    4'd0: carrier_state = (res.sym == SYM_MARKER);
                    4'd1: if (res.sym == SYM_ZERO) carrier_state = 1'b1;
                    4'd2: carrier_state = 1'b1;
                    default: ;
                endcase
                tenth_count    = (phase >= LAST_TENTH) ? 4'd0 : phase + 4'd1;
                res.carrier_on = carrier_state;
                res.tenth      = phase;
            end
            expected_q.push_back(res);
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= MAX_REPORTS) $display("%s", msg);
        endfunction

        function void check_result(logic [TDATA_OW-1:0] d);
            t_carrier got;
            t_carrier want;
            got.carrier_on = d[0];
            got.sym        = d[2:1];
            got.tenth      = d[6:3];
            if (expected_q.size() == 0) begin
                flag($sformatf("unexpected item: carrier %0b symbol %0d tenth %0d",
                               got.carrier_on, got.sym, got.tenth));
                return;
            end
            want = expected_q.pop_front();
            if (got.carrier_on !== want.carrier_on || got.sym !== want.sym ||
                got.tenth !== want.tenth) begin
                flag($sformatf({"mismatch: expected carrier %0b symbol %0d tenth %0d, ",
                                "got carrier %0b symbol %0d tenth %0d"},
                               want.carrier_on, want.sym, want.tenth,
                               got.carrier_on, got.sym, got.tenth));
            end
        endfunction
    endclass

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_wr_en   = 1'b0;
    logic                i_cfg_wr_data = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // second, minute, hour, day, weekday, month, year_of_century, summer_time, pad
    logic [TDATA_IW-1:0] s_axis_tdata  = '0;
    // time_valid
    logic                s_axis_tuser  = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // carrier_on, symbol, tenth, pad
    logic [TDATA_OW-1:0] m_axis_tdata;

    t_carrier_scoreboard sb = new();

    bit no_idle    = 1'b0;  // full-rate stretch on both sides
    bit hold_req   = 1'b0;  // asks the receiver for one long hold-off
    int live_items = 0;     // ticks that the block actually acts on

    dcf77_time_code_modulator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // second sits in the lowest bits, summer_time on top, zero pad above
    function automatic logic [TDATA_IW-1:0] pack_time(t_time t);
        return TDATA_IW'({t.summer_time, t.year_of_century, t.month, t.weekday,
                          t.day, t.hour, t.minute, t.second});
    endfunction

    function automatic t_time mk_time(int sec, int mnt, int hr, int dom, int wd,
                                      int mon, int yr, int st);
        t_time t;
        t.second          = 6'(sec);
        t.minute          = 6'(mnt);
        t.hour            = 5'(hr);
        t.day             = 5'(dom);
        t.weekday         = 3'(wd);
        t.month           = 4'(mon);
        t.year_of_century = 7'(yr);
        t.summer_time     = 1'(st);
        return t;
    endfunction

    // wild times use the whole width of every field
    function automatic t_time rand_time(bit wild);
        if (wild) begin
            return mk_time($urandom_range(0, 63), $urandom_range(0, 63),
                           $urandom_range(0, 31), $urandom_range(0, 31),
                           $urandom_range(0, 7), $urandom_range(0, 15),
                           $urandom_range(0, 127), $urandom_range(0, 1));
        end
        return mk_time($urandom_range(0, 59), $urandom_range(0, 59),
                       $urandom_range(0, 23), $urandom_range(1, 31),
                       $urandom_range(0, 6), $urandom_range(1, 12),
                       $urandom_range(0, 99), $urandom_range(0, 1));
    endfunction

    // offer one tick and wait for the handshake; tvalid stays high on return
    task automatic send_tick(input logic valid, input t_time t);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_time(t);
        s_axis_tuser  <= valid;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_tick(valid, t);
        if (valid && sb.tx_enable) live_items++;
    endtask

    // register write once the pipeline has emptied
    task automatic write_enable(input bit v);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.set_enable(v);
    endtask

    // a run of 3 to 24 seconds, mostly of well-formed time, ten ticks per second as a rule
    task automatic send_run();
        t_time t;
        int    nsec;
        int    ticks;
        t        = rand_time($urandom_range(0, 9) == 0);
        t.second = 6'($urandom_range(0, 59));
        nsec     = $urandom_range(3, 24);
        repeat (nsec) begin
            ticks = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 12) : 10;
            repeat (ticks) send_tick($urandom_range(0, 31) != 0, t);
            // advance the clock, rolling the minute over after the marker
            if (t.second >= MARKER_SECOND) begin
                t.second = '0;
                t.minute = (t.minute >= 59) ? 6'd0 : t.minute + 6'd1;
            end else begin
                t.second = t.second + 6'd1;
            end
        end
    endtask

    task automatic run_random(input int n_live);
        int  stop;
        int  half;
        bit  held;
        stop = live_items + n_live;
        half = live_items + n_live / 2;
        held = 1'b0;
        while (live_items < stop) begin
            no_idle = ($urandom_range(0, 6) == 0);
            // one long hold-off per phase while ticks keep coming
            if (!held && live_items >= half) begin
                hold_req = 1'b1;
                held     = 1'b1;
            end
            if ($urandom_range(0, 99) < 75) begin
                send_run();
            end else begin
                repeat ($urandom_range(1, 15)) send_tick($urandom_range(0, 1), rand_time(1'b1));
            end
        end
        no_idle = 1'b0;
    endtask

    // receiver: checks results and applies back-pressure
    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                stall_left = pick_gap();
                if (stall_left > 0) begin
                    stall_left--;
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    // watchdog: too long without any handshake ends the run
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // stimulus
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // disabled: ticks must leave the carrier alone
        write_enable(1'b0);
        send_tick(1'b1, mk_time(20, 30, 12, 15, 3, 6, 24, 1));
        send_tick(1'b0, mk_time(5, 30, 12, 15, 3, 6, 24, 0));

        write_enable(1'b1);
        // invalid time while enabled
        send_tick(1'b0, mk_time(5, 30, 12, 15, 3, 6, 24, 0));
        // all fields at zero, three phases of a zero bit
        repeat (3) send_tick(1'b1, mk_time(0, 0, 0, 0, 0, 0, 0, 0));
        // minute marker keeps full carrier
        repeat (2) send_tick(1'b1, mk_time(59, 10, 8, 3, 2, 4, 21, 0));
        // second past the marker acts as a marker
        send_tick(1'b1, mk_time(63, 10, 8, 3, 2, 4, 21, 0));
        // every field at its top value, date parity slot
        send_tick(1'b1, mk_time(58, 63, 31, 31, 7, 15, 127, 1));
        // minute wrap carries into the hour, hour wraps past midnight
        send_tick(1'b1, mk_time(21, 59, 23, 31, 6, 12, 99, 0));
        send_tick(1'b1, mk_time(29, 59, 23, 31, 6, 12, 99, 0));
        // sunday goes out as seven
        send_tick(1'b1, mk_time(42, 10, 12, 15, 0, 6, 24, 1));
        // dst flags
        send_tick(1'b1, mk_time(17, 10, 12, 15, 4, 6, 24, 1));
        send_tick(1'b1, mk_time(18, 10, 12, 15, 4, 6, 24, 0));
        send_tick(1'b1, mk_time(17, 10, 12, 15, 4, 6, 24, 0));
        // start bit gives a long pulse, an ordinary zero a short one
        repeat (3) send_tick(1'b1, mk_time(20, 10, 12, 15, 4, 6, 24, 0));
        repeat (3) send_tick(1'b1, mk_time(19, 10, 12, 15, 4, 6, 24, 0));

        run_random(600);

        // disabled again with noise
        write_enable(1'b0);
        repeat (60) send_tick($urandom_range(0, 1), rand_time(1'b1));

        write_enable(1'b1);
        run_random(600);

        // drain
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: dcf77_time_code_modulator.f
+incdir+rtl/core
rtl/core/dcf77_pkg.sv
rtl/core/dcf77_time_code_modulator.sv
bench/tb.sv
